>>> src/rabg_pkg.sv
// Shared types and constants for the rotated alpha blend of a gray image
`timescale 1ns / 1ps

package rabg_pkg;

  localparam int IMG_W_DEF     = 480;
  localparam int IMG_H_DEF     = 480;
  localparam int FRAC_BITS_DEF = 14;

  localparam int CFG_W   = 16;
  localparam int ADDR_W  = 18;
  localparam int COORD_W = 9;
  localparam int CHAN_W  = 8;
  localparam int TEXEL_W = 8;
  localparam int NIB_W   = 4;

  localparam logic [NIB_W-1:0] ALPHA_NONE = 4'h0;
  localparam logic [NIB_W-1:0] ALPHA_FULL = 4'hF;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_BLEND = 1'b1
  } op_t;

  typedef enum logic [0:0] {
    REG_COS = 1'b0,
    REG_SIN = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } rgb_t;

  // hit: load address inside the image, or blend sample inside the image
  typedef struct packed {
    op_t  op;
    logic hit;
  } ctl_t;

endpackage

>>> src/rabg_ram.sv
// Generic simple dual-port RAM, one write and one registered read port
`timescale 1ns / 1ps

module rabg_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/rabg_coord.sv
// Four-stage coordinate pipe: rotate, sum, range check, texel address
`timescale 1ns / 1ps

module rabg_coord #(
  parameter int IMG_W     = rabg_pkg::IMG_W_DEF,
  parameter int IMG_H     = rabg_pkg::IMG_H_DEF,
  parameter int FRAC_BITS = rabg_pkg::FRAC_BITS_DEF,
  parameter int AW        = $clog2(IMG_W * IMG_H)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic signed [rabg_pkg::CFG_W-1:0]   cos_i,
  input  logic signed [rabg_pkg::CFG_W-1:0]   sin_i,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rabg_pkg::op_t                       in_op,
  input  logic [rabg_pkg::ADDR_W-1:0]         in_tex_addr,
  input  logic [rabg_pkg::TEXEL_W-1:0]        in_texel,
  input  logic [rabg_pkg::COORD_W-1:0]        in_dst_x,
  input  logic [rabg_pkg::COORD_W-1:0]        in_dst_y,
  input  rabg_pkg::rgb_t                      in_rgb,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rabg_pkg::ctl_t                      out_ctl,
  output logic [AW-1:0]                       out_addr,
  output logic [rabg_pkg::TEXEL_W-1:0]        out_texel,
  output rabg_pkg::rgb_t                      out_rgb
);

  localparam int NST  = 4;
  localparam int MAXD = (IMG_W > IMG_H) ? IMG_W : IMG_H;
  localparam int FW   = $clog2(MAXD / 2 + 512) + 1;
  localparam int PW   = FW + rabg_pkg::CFG_W;
  localparam int BW   = $clog2(MAXD) + FRAC_BITS + 1;
  localparam int SW   = ((PW > BW) ? PW : BW) + 2;
  localparam int QW   = SW - FRAC_BITS;
  localparam int XW   = $clog2(IMG_W);
  localparam int YW   = $clog2(IMG_H);
  localparam int NUM  = IMG_W * IMG_H;
  localparam int HALF = 2 ** (FRAC_BITS - 1);

  localparam logic signed [SW-1:0] BASE_U = SW'((IMG_W / 2) * (2 ** FRAC_BITS) + HALF);
  localparam logic signed [SW-1:0] BASE_V = SW'((IMG_H / 2) * (2 ** FRAC_BITS) + HALF);
  localparam logic [QW-1:0]        LIM_X  = QW'(IMG_W);
  localparam logic [QW-1:0]        LIM_Y  = QW'(IMG_H);
  localparam logic [AW-1:0]        IMG_W_A = AW'(IMG_W);

  logic [NST-1:0] v_r;
  logic [NST-1:0] v_nxt;
  logic [NST-1:0] en;

  // stall chain: a stage moves when it is empty or the one after it moves
  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt = v_r;
    if (en[0]) begin
      v_nxt[0] = in_valid;
    end
    for (int k = 1; k < NST; k++) begin
      if (en[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready = en[0];

  // stage 1: centre offsets and the four rotation products
  logic signed [FW-1:0] fx, fy;
  logic signed [PW-1:0] xc_nxt, ys_nxt, xs_nxt, yc_nxt;
  logic                 lhit_nxt;

  assign fx       = $signed(FW'(in_dst_x)) - $signed(FW'(IMG_W / 2));
  assign fy       = $signed(FW'(in_dst_y)) - $signed(FW'(IMG_H / 2));
  assign xc_nxt   = fx * cos_i;
  assign ys_nxt   = fy * sin_i;
  assign xs_nxt   = fx * sin_i;
  assign yc_nxt   = fy * cos_i;
  assign lhit_nxt = 32'(in_tex_addr) < 32'(NUM);

  rabg_pkg::op_t             op1_r;
  logic                      lhit1_r;
  logic [AW-1:0]             taddr1_r;
  logic [rabg_pkg::TEXEL_W-1:0] texel1_r;
  rabg_pkg::rgb_t            rgb1_r;
  logic signed [PW-1:0]      xc1_r, ys1_r, xs1_r, yc1_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      op1_r    <= in_op;
      lhit1_r  <= lhit_nxt;
      taddr1_r <= AW'(in_tex_addr);
      texel1_r <= in_texel;
      rgb1_r   <= in_rgb;
      xc1_r    <= xc_nxt;
      ys1_r    <= ys_nxt;
      xs1_r    <= xs_nxt;
      yc1_r    <= yc_nxt;
    end
  end

  // stage 2: exact source position, rounding bias included
  logic signed [SW-1:0] u_nxt, v_nxt_pos;

  assign u_nxt     = BASE_U + SW'(xc1_r) + SW'(ys1_r);
  assign v_nxt_pos = BASE_V - SW'(xs1_r) + SW'(yc1_r);

  rabg_pkg::op_t             op2_r;
  logic                      lhit2_r;
  logic [AW-1:0]             taddr2_r;
  logic [rabg_pkg::TEXEL_W-1:0] texel2_r;
  rabg_pkg::rgb_t            rgb2_r;
  logic signed [SW-1:0]      u2_r, v2_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      op2_r    <= op1_r;
      lhit2_r  <= lhit1_r;
      taddr2_r <= taddr1_r;
      texel2_r <= texel1_r;
      rgb2_r   <= rgb1_r;
      u2_r     <= u_nxt;
      v2_r     <= v_nxt_pos;
    end
  end

  // stage 3: truncate toward zero and check against the image edges.
  // A negative position above -1.0 truncates to column or row zero.
  logic [QW-1:0] uq, vq;
  logic          x_ok, y_ok, hit_nxt;
  logic [XW-1:0] sx_nxt;
  logic [YW-1:0] sy_nxt;

  always_comb begin
    uq = u2_r[SW-1:FRAC_BITS];
    vq = v2_r[SW-1:FRAC_BITS];
    if (u2_r[SW-1]) begin
      x_ok   = (&uq) && (|u2_r[FRAC_BITS-1:0]);
      sx_nxt = '0;
    end else begin
      x_ok   = uq < LIM_X;
      sx_nxt = uq[XW-1:0];
    end
    if (v2_r[SW-1]) begin
      y_ok   = (&vq) && (|v2_r[FRAC_BITS-1:0]);
      sy_nxt = '0;
    end else begin
      y_ok   = vq < LIM_Y;
      sy_nxt = vq[YW-1:0];
    end
    hit_nxt = (op2_r == rabg_pkg::OP_LOAD) ? lhit2_r : (x_ok && y_ok);
  end

  rabg_pkg::op_t             op3_r;
  logic                      hit3_r;
  logic [AW-1:0]             taddr3_r;
  logic [rabg_pkg::TEXEL_W-1:0] texel3_r;
  rabg_pkg::rgb_t            rgb3_r;
  logic [XW-1:0]             sx3_r;
  logic [YW-1:0]             sy3_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      op3_r    <= op2_r;
      hit3_r   <= hit_nxt;
      taddr3_r <= taddr2_r;
      texel3_r <= texel2_r;
      rgb3_r   <= rgb2_r;
      sx3_r    <= sx_nxt;
      sy3_r    <= sy_nxt;
    end
  end

  // stage 4: row-major texel address
  logic [AW-1:0] addr_nxt;

  assign addr_nxt = (op3_r == rabg_pkg::OP_LOAD) ? taddr3_r
                                                 : AW'(sy3_r) * IMG_W_A + AW'(sx3_r);

  rabg_pkg::ctl_t            ctl4_r;
  logic [AW-1:0]             addr4_r;
  logic [rabg_pkg::TEXEL_W-1:0] texel4_r;
  rabg_pkg::rgb_t            rgb4_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      ctl4_r.op  <= op3_r;
      ctl4_r.hit <= hit3_r;
      addr4_r    <= addr_nxt;
      texel4_r   <= texel3_r;
      rgb4_r     <= rgb3_r;
    end
  end

  assign out_valid = v_r[NST-1];
  assign out_ctl   = ctl4_r;
  assign out_addr  = addr4_r;
  assign out_texel = texel4_r;
  assign out_rgb   = rgb4_r;

endmodule

>>> src/rabg_blend.sv
// Two-stage blend: alpha products, then divide by 255 and select
`timescale 1ns / 1ps

module rabg_blend (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_hit,
  input  logic [rabg_pkg::TEXEL_W-1:0]  in_texel,
  input  rabg_pkg::rgb_t                in_rgb,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rabg_pkg::rgb_t                out_rgb,
  output logic                          out_covered
);

  localparam int CW = rabg_pkg::CHAN_W;
  localparam int PW = 2 * CW;

  // exact x/255 for x up to 255*255
  function automatic logic [CW-1:0] div255(input logic [PW:0] x);
    logic [PW:0] t;
    t = x + (x >> CW) + (PW + 1)'(1);
    return t[PW-1:CW];
  endfunction

  logic [1:0] v_r, v_nxt, en;

  always_comb begin
    en[1] = !v_r[1] || out_ready;
    en[0] = !v_r[0] || en[1];
    v_nxt = v_r;
    if (en[0]) begin
      v_nxt[0] = in_valid;
    end
    if (en[1]) begin
      v_nxt[1] = v_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready = en[0];

  // stage 1: nibble*17 is the nibble repeated
  logic [rabg_pkg::NIB_W-1:0] a4, g4;
  logic [CW-1:0]              alpha, gray, inv;

  assign a4    = in_texel[rabg_pkg::TEXEL_W-1:rabg_pkg::NIB_W];
  assign g4    = in_texel[rabg_pkg::NIB_W-1:0];
  assign alpha = {a4, a4};
  assign gray  = {g4, g4};
  assign inv   = ~alpha;

  logic           cov1_r, full1_r;
  logic [CW-1:0]  gray1_r;
  rabg_pkg::rgb_t d1_r;
  logic [PW-1:0]  ga1_r, dr1_r, dg1_r, db1_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cov1_r  <= in_hit && (a4 != rabg_pkg::ALPHA_NONE);
      full1_r <= a4 == rabg_pkg::ALPHA_FULL;
      gray1_r <= gray;
      d1_r    <= in_rgb;
      ga1_r   <= gray * alpha;
      dr1_r   <= in_rgb.red * inv;
      dg1_r   <= in_rgb.green * inv;
      db1_r   <= in_rgb.blue * inv;
    end
  end

  // stage 2
  rabg_pkg::rgb_t rgb_nxt;

  always_comb begin
    if (!cov1_r) begin
      rgb_nxt = d1_r;
    end else if (full1_r) begin
      rgb_nxt.red   = gray1_r;
      rgb_nxt.green = gray1_r;
      rgb_nxt.blue  = gray1_r;
    end else begin
      rgb_nxt.red   = div255((PW + 1)'(ga1_r) + (PW + 1)'(dr1_r));
      rgb_nxt.green = div255((PW + 1)'(ga1_r) + (PW + 1)'(dg1_r));
      rgb_nxt.blue  = div255((PW + 1)'(ga1_r) + (PW + 1)'(db1_r));
    end
  end

  rabg_pkg::rgb_t rgb2_r;
  logic           cov2_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      rgb2_r <= rgb_nxt;
      cov2_r <= cov1_r;
    end
  end

  assign out_valid   = v_r[1];
  assign out_rgb     = rgb2_r;
  assign out_covered = cov2_r;

endmodule

>>> src/rotate_alpha_blend_gray.sv
// Top level: rotated nearest-texel alpha blend of a stored gray image
`timescale 1ns / 1ps

// Channel   Dir  Handshake                 Word contents
// in_       in   in_tvalid / in_tready     tuser: op; tdata: texel addr, texel,
//                                          dst x, dst y, red, green, blue
// out_      out  out_tvalid / out_tready   tuser: covered; tdata: red, green, blue
// cfg_      in   cfg_we                    cfg_index selects cos or sin, cfg_data
//
// One word accepted per cycle unless the pipe is stalled. A blend word passes
// through 4 coordinate stages (products, sums, range check, address), the
// texel RAM read stage, and 2 blend stages. Load words write the RAM at the
// read stage and produce nothing, so loads and reads keep their order.
// Each stage moves when it is empty or the next one moves, so bubbles close
// up and a full output register does not stop input while stages are free.
// Synchronous active-low reset clears valid bits and sets the angle registers
// to cos 1.0 and sin 0; the texel RAM is not cleared.

module rotate_alpha_blend_gray #(
  parameter int IMG_W     = rabg_pkg::IMG_W_DEF,
  parameter int IMG_H     = rabg_pkg::IMG_H_DEF,
  parameter int FRAC_BITS = rabg_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic                        in_tuser,   // [0] op
  // [17:0] tex_addr, [25:18] texel, [34:26] dst_x, [43:35] dst_y,
  // [51:44] dst_red, [59:52] dst_green, [67:60] dst_blue, [71:68] zero
  input  logic [71:0]                 in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic                        out_tuser,  // [0] covered
  output logic [23:0]                 out_tdata,  // [7:0] red, [15:8] green, [23:16] blue
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [rabg_pkg::CFG_W-1:0]  cfg_data
);

  localparam int NUM = IMG_W * IMG_H;
  localparam int AW  = $clog2(NUM);
  localparam logic signed [rabg_pkg::CFG_W-1:0] COS_RST = rabg_pkg::CFG_W'(2 ** FRAC_BITS);
  localparam logic signed [rabg_pkg::CFG_W-1:0] SIN_RST = '0;

  // angle registers
  logic signed [rabg_pkg::CFG_W-1:0] cos_r, sin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r <= COS_RST;
      sin_r <= SIN_RST;
    end else if (cfg_we) begin
      unique case (rabg_pkg::reg_idx_t'(cfg_index))
        rabg_pkg::REG_COS: cos_r <= cfg_data;
        rabg_pkg::REG_SIN: sin_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // input word unpacking
  rabg_pkg::rgb_t in_rgb;

  assign in_rgb.red   = in_tdata[51:44];
  assign in_rgb.green = in_tdata[59:52];
  assign in_rgb.blue  = in_tdata[67:60];

  logic                         crd_valid, crd_ready;
  rabg_pkg::ctl_t               crd_ctl;
  logic [AW-1:0]                crd_addr;
  logic [rabg_pkg::TEXEL_W-1:0] crd_texel;
  rabg_pkg::rgb_t               crd_rgb;

  rabg_coord #(
    .IMG_W     (IMG_W),
    .IMG_H     (IMG_H),
    .FRAC_BITS (FRAC_BITS),
    .AW        (AW)
  ) u_coord (
    .clk         (clk),
    .rst_n       (rst_n),
    .cos_i       (cos_r),
    .sin_i       (sin_r),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_op       (rabg_pkg::op_t'(in_tuser)),
    .in_tex_addr (in_tdata[17:0]),
    .in_texel    (in_tdata[25:18]),
    .in_dst_x    (in_tdata[34:26]),
    .in_dst_y    (in_tdata[43:35]),
    .in_rgb      (in_rgb),
    .out_valid   (crd_valid),
    .out_ready   (crd_ready),
    .out_ctl     (crd_ctl),
    .out_addr    (crd_addr),
    .out_texel   (crd_texel),
    .out_rgb     (crd_rgb)
  );

  // RAM stage: loads write here and leave the pipe, blends read
  logic                         mem_v_r, mem_v_nxt, mem_en;
  logic                         mem_hit_r;
  rabg_pkg::rgb_t               mem_rgb_r;
  logic                         ram_we, ram_re;
  logic [rabg_pkg::TEXEL_W-1:0] ram_rdata;
  logic                         bl_ready;

  assign mem_en    = !mem_v_r || bl_ready;
  assign crd_ready = mem_en;
  assign ram_we    = mem_en && crd_valid && (crd_ctl.op == rabg_pkg::OP_LOAD) && crd_ctl.hit;
  assign ram_re    = mem_en && crd_valid && (crd_ctl.op == rabg_pkg::OP_BLEND) && crd_ctl.hit;
  assign mem_v_nxt = mem_en ? (crd_valid && (crd_ctl.op == rabg_pkg::OP_BLEND)) : mem_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_v_r <= 1'b0;
    end else begin
      mem_v_r <= mem_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_en) begin
      mem_hit_r <= crd_ctl.hit;
      mem_rgb_r <= crd_rgb;
    end
  end

  rabg_ram #(
    .W     (rabg_pkg::TEXEL_W),
    .DEPTH (NUM)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (crd_addr),
    .wdata (crd_texel),
    .re    (ram_re),
    .raddr (crd_addr),
    .rdata (ram_rdata)
  );

  rabg_pkg::rgb_t out_rgb;

  rabg_blend u_blend (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (mem_v_r),
    .in_ready    (bl_ready),
    .in_hit      (mem_hit_r),
    .in_texel    (ram_rdata),
    .in_rgb      (mem_rgb_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_rgb     (out_rgb),
    .out_covered (out_tuser)
  );

  assign out_tdata = {out_rgb.blue, out_rgb.green, out_rgb.red};

endmodule

>>> src/rabg_checker.sv
// Port-level checks on the rotated alpha blend top level, with bind
`timescale 1ns / 1ps

module rabg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic        out_tuser,
  input logic [23:0] out_tdata
);

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word valid straight after reset");

  // with the output free every stage moves, so input is never held off
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input stalled while the output side is free");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed or dropped under stall");

  // a blend word taken into an unstalled pipe reaches the output
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser ##1 out_tready ##1 out_tready ##1 out_tready
    ##1 out_tready ##1 out_tready ##1 out_tready |=> out_tvalid)
    else $error("blend word lost in an unstalled pipe");

endmodule

bind rotate_alpha_blend_gray rabg_checker u_rabg_checker (.*);

>>> bench/testbench.sv
// Self-checking testbench for the rotated alpha blend of a gray source image
`timescale 1ns / 1ps

// The bench keeps its own copy of the texel store and of the two angle
// registers. It predicts every blend word as it is accepted on the input side
// and checks the results in order on the output side. Loads produce nothing.
//
// The source image is never read where it has not been written. Before each
// blend the generator works out which texel the pixel lands on under the
// current angle. If that texel is still unwritten, it loads a random one first.
//
// Run order:
//   - a short directed part at the reset angle, where the texel under a pixel
//     is the pixel itself: full alpha, zero alpha, light and heavy mixing,
//     colour extremes, ignored loads past the end of the image, a texel
//     overwritten and then read back
//   - a series of angle settings, the extremes among them. Each one is
//     written while the block is idle and is followed by random traffic.
//   - the first setting also aims at samples just left of and just above the
//     image, which truncate to column or row 0, and at one just outside.
// Both sides idle at random, with calm stretches. Once, the sink holds off
// for a long time so that the pipe fills and stalls the input.

module testbench;
  import rabg_pkg::*;

  localparam int IMG_W  = IMG_W_DEF;
  localparam int IMG_H  = IMG_H_DEF;
  localparam int FRAC   = FRAC_BITS_DEF;
  localparam int TEXELS = IMG_W * IMG_H;

  localparam int NUM_PHASES  = 8;
  localparam int PHASE_WORDS = 210;
  localparam int SETTLE_CYC  = 16;    // pipe is 7 deep; loads leave no trace
  localparam int LONG_HOLD   = 400;
  localparam int HOLD_AFTER  = 150;   // results seen before the long hold

  // in_tdata layout, lowest bits last in the list
  typedef struct packed {
    logic [3:0]         pad;
    rgb_t               color;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
    logic [TEXEL_W-1:0] texel;
    logic [ADDR_W-1:0]  addr;
  } pix_word_t;

  typedef struct packed {
    op_t       op;
    pix_word_t f;
  } pix_item_t;

  typedef struct packed {
    logic covered;
    rgb_t color;
  } pix_out_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid  = 1'b0;
  logic        in_tuser   = 1'b0;
  logic [71:0] in_tdata   = '0;
  logic        out_tready = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [0:0]  cfg_index  = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic        in_tready;
  logic        out_tvalid;
  logic        out_tuser;
  logic [23:0] out_tdata;

  rotate_alpha_blend_gray dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),    // [0] op
    .in_tdata   (in_tdata),    // addr, texel, x, y, red, green, blue, pad
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),   // [0] covered
    .out_tdata  (out_tdata),   // red, green, blue
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // --- predictor state -----------------------------------------------------
  bit   [TEXEL_W-1:0] tex_img [TEXELS];     // texels as the block holds them
  bit                 tex_loaded [TEXELS];  // generator side: written yet?
  logic signed [CFG_W-1:0] ang_cos = 16'sd16384;
  logic signed [CFG_W-1:0] ang_sin = 16'sd0;

  pix_item_t word_fifo [$];   // words waiting to be offered
  pix_out_t  pixel_due [$];   // predicted blend results, oldest first

  int   words_made   = 0;
  int   mismatches   = 0;
  int   results_seen = 0;
  bit   send_calm    = 1'b0;
  bit   sink_calm    = 1'b0;
  int   send_gap     = 0;
  int   sink_hold    = 0;
  bit   long_hold_done = 1'b0;

  // last blend pushed, for overwrite-and-reread traffic
  logic [COORD_W-1:0] last_x, last_y;
  int   last_idx;
  bit   last_hit = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Rotate a destination pixel into the source image. Sums are exact; the
  // division truncates toward zero, as does SV integer division.
  function automatic bit map_to_source(input logic [COORD_W-1:0] x, y,
                                       output int idx);
    longint fx, fy, u, v, sx, sy, half;
    fx   = longint'(x) - IMG_W / 2;
    fy   = longint'(y) - IMG_H / 2;
    half = longint'(1) << (FRAC - 1);
    u  = (longint'(IMG_W / 2) << FRAC) + fx * ang_cos + fy * ang_sin + half;
    v  = (longint'(IMG_H / 2) << FRAC) - fx * ang_sin + fy * ang_cos + half;
    sx = u / (longint'(1) << FRAC);
    sy = v / (longint'(1) << FRAC);
    idx = 0;
    if (sx < 0 || sx >= IMG_W || sy < 0 || sy >= IMG_H) return 1'b0;
    idx = int'(sy * IMG_W + sx);
    return 1'b1;
  endfunction

  function automatic logic [CHAN_W-1:0] mix_chan(int g, int d, int a);
    return CHAN_W'((g * a + d * (255 - a)) / 255);
  endfunction

  // Runs on every accepted word: loads update the store, blends queue a result
  function automatic void predict_word(pix_item_t it);
    int idx;
    logic [TEXEL_W-1:0] p;
    int a, g;
    pix_out_t res;
    if (it.op == OP_LOAD) begin
      if (it.f.addr < TEXELS) tex_img[it.f.addr] = it.f.texel;
      return;
    end
    res.covered = 1'b0;
    res.color   = it.f.color;
    if (map_to_source(it.f.x, it.f.y, idx)) begin
      p = tex_img[idx];
      a = p[7:4] * 17;
      g = p[3:0] * 17;
      if (p[7:4] != ALPHA_NONE) begin
        res.covered = 1'b1;
        if (p[7:4] == ALPHA_FULL) begin
          res.color = {3{CHAN_W'(g)}};
        end else begin
          res.color.red   = mix_chan(g, it.f.color.red, a);
          res.color.green = mix_chan(g, it.f.color.green, a);
          res.color.blue  = mix_chan(g, it.f.color.blue, a);
        end
      end
    end
    pixel_due.push_back(res);
  endfunction

  // Mostly no gap, some short, a few long; none at all in a calm stretch
  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [TEXEL_W-1:0] rand_texel();
    int r;
    logic [3:0] a;
    r = $urandom_range(0, 99);
    a = (r < 15) ? ALPHA_NONE : (r < 35) ? ALPHA_FULL : 4'($urandom_range(0, 15));
    return {a, 4'($urandom_range(0, 15))};
  endfunction

  function automatic rgb_t rand_color();
    rgb_t c;
    c = 24'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      c.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      c.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      c.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end
    return c;
  endfunction

  // Unused fields of a word carry noise, apart from the pad, which is zero
  task automatic push_load(int unsigned addr, logic [TEXEL_W-1:0] texel);
    pix_item_t it;
    it.op      = OP_LOAD;
    it.f.pad   = '0;
    it.f.color = 24'($urandom);
    it.f.x     = COORD_W'($urandom);
    it.f.y     = COORD_W'($urandom);
    it.f.addr  = ADDR_W'(addr);
    it.f.texel = texel;
    word_fifo.push_back(it);
    words_made++;
    if (addr < TEXELS) tex_loaded[addr] = 1'b1;
  endtask

  task automatic push_blend(logic [COORD_W-1:0] x, y, rgb_t color);
    pix_item_t it;
    int idx;
    bit hit;
    hit = map_to_source(x, y, idx);
    if (hit && !tex_loaded[idx]) push_load(idx, rand_texel());
    it.op      = OP_BLEND;
    it.f.pad   = '0;
    it.f.color = color;
    it.f.x     = x;
    it.f.y     = y;
    it.f.addr  = ADDR_W'($urandom);
    it.f.texel = TEXEL_W'($urandom);
    word_fifo.push_back(it);
    words_made++;
    last_x   = x;
    last_y   = y;
    last_idx = idx;
    last_hit = hit;
  endtask

  task automatic run_random(int n);
    int stop, r;
    stop = words_made + n;
    while (words_made < stop) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        push_blend($urandom_range(0, IMG_W - 1), $urandom_range(0, IMG_H - 1),
                   rand_color());
      end else if (r < 72) begin
        push_load($urandom_range(0, TEXELS - 1), rand_texel());
      end else if (r < 90 && last_hit) begin
        // rewrite the texel just sampled, then blend the same pixel again
        push_load(last_idx, rand_texel());
        push_blend(last_x, last_y, rand_color());
      end else if (r < 95) begin
        push_load($urandom_range(TEXELS, (1 << ADDR_W) - 1), rand_texel());
      end else begin
        push_blend($urandom_range(0, 1) ? IMG_W - 1 : 0,
                   $urandom_range(0, 1) ? IMG_H - 1 : 0, rand_color());
      end
    end
  endtask

  // Block idle: nothing queued, nothing offered, nothing due, pipe flushed
  task automatic settle();
    while (word_fifo.size() != 0 || in_tvalid || pixel_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_angle(reg_idx_t idx, logic signed [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_COS) ang_cos = val;
    else ang_sin = val;
  endtask

  // --- sender: offers words from word_fifo, predicts them on acceptance ---
  always @(posedge clk) begin : drive_in
    pix_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) predict_word(pix_item_t'({in_tuser, in_tdata}));
      if ($urandom_range(0, 63) == 0) send_calm <= !send_calm;
      if (send_gap != 0) begin
        send_gap  <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (word_fifo.size() != 0) begin
        nxt = word_fifo.pop_front();
        in_tuser  <= nxt.op;
        in_tdata  <= nxt.f;
        in_tvalid <= 1'b1;
        send_gap  <= pick_gap(send_calm);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // --- sink ready: random stalls, plus one long hold to back the pipe up ---
  always @(posedge clk) begin : drive_ready
    int g;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (sink_hold != 0) begin
      sink_hold  <= sink_hold - 1;
      out_tready <= 1'b0;
    end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
      long_hold_done <= 1'b1;
      sink_hold      <= LONG_HOLD;
      out_tready     <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) sink_calm <= !sink_calm;
      g = pick_gap(sink_calm);
      out_tready <= (g == 0);
      sink_hold  <= (g == 0) ? 0 : g - 1;
    end
  end

  task automatic flag_pixel(string why, pix_out_t want, pix_out_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: want r=%0d g=%0d b=%0d cov=%0d, got r=%0d g=%0d b=%0d cov=%0d",
               $realtime, why, want.color.red, want.color.green, want.color.blue,
               want.covered, got.color.red, got.color.green, got.color.blue,
               got.covered);
  endtask

  // --- monitor: each result word against the oldest prediction -----------
  always @(posedge clk) begin : check_out
    pix_out_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      got = pix_out_t'({out_tuser, out_tdata});
      if (pixel_due.size() == 0) begin
        flag_pixel("result word with nothing due", '0, got);
      end else begin
        want = pixel_due.pop_front();
        if (got.color.red !== want.color.red || got.color.green !== want.color.green ||
            got.color.blue !== want.color.blue || got.covered !== want.covered)
          flag_pixel("pixel mismatch", want, got);
      end
    end
  end

  // --- stimulus ------------------------------------------------------------
  initial begin : stimulus
    logic signed [CFG_W-1:0] cos_tab [NUM_PHASES];
    logic signed [CFG_W-1:0] sin_tab [NUM_PHASES];
    logic signed [CFG_W-1:0] c, s;
    // last two settings are drawn at random
    cos_tab = '{16384, -16384, 0,     0,      11585, -16384, 0, 0};
    sin_tab = '{16384, 0,      16384, -16384, 11585, -16384, 0, 0};

    wait (rst_n === 1'b1);

    // Reset angle: each pixel samples its own texel
    push_load(0, 8'hF0);                  // full alpha, black
    push_load(TEXELS - 1, 8'hFF);         // full alpha, white, last texel
    push_load(TEXELS, 8'h5A);             // past the end: ignored
    push_load((1 << ADDR_W) - 1, 8'hA5);  // top of the address field: ignored
    push_load(IMG_W - 1, 8'h0F);          // zero alpha
    push_load(TEXELS - IMG_W, 8'h1E);     // faintest alpha
    push_load(1, 8'hE1);                  // heavy alpha, dark
    push_load(2, 8'h00);
    push_blend(0, 0, {8'hFF, 8'hFF, 8'hFF});
    push_blend(IMG_W - 1, IMG_H - 1, '0);
    push_blend(IMG_W - 1, 0, {8'd56, 8'd34, 8'd12});
    push_blend(0, IMG_H - 1, {8'hFF, 8'h00, 8'hFF});
    push_blend(1, 0, {8'd128, 8'hFF, 8'h00});
    push_blend(2, 0, rand_color());
    push_load(0, 8'h7C);                  // overwrite, then read back
    push_blend(0, 0, {8'd50, 8'd100, 8'd200});
    settle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      c = cos_tab[ph];
      s = sin_tab[ph];
      if (ph >= NUM_PHASES - 2) begin
        c = $urandom_range(0, 32768) - 16384;
        s = $urandom_range(0, 32768) - 16384;
      end
      write_angle(REG_COS, c);
      write_angle(REG_SIN, s);
      if (ph == 0) begin
        // cos = sin = 1.0: u sits half a texel left of column 0, then v half
        // a texel above row 0; both truncate to 0. Then one just outside.
        push_blend(120, 119, rand_color());
        push_blend(300, 59, rand_color());
        push_blend(120, 118, rand_color());
      end
      run_random(PHASE_WORDS);
      settle();
    end

    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #(15_000_000);
    $display("testbench NOT OK");
    $finish;
  end

endmodule

>>> filelist.f
src/rabg_pkg.sv
src/rabg_ram.sv
src/rabg_coord.sv
src/rabg_blend.sv
src/rotate_alpha_blend_gray.sv
src/rabg_checker.sv
bench/testbench.sv
